/* design/ws2_pkg.sv */
// Shared types and constants for the LED strip PWM frame encoder.
package ws2_pkg;

   localparam int PIXEL_W   = 24;
   localparam int SLOT_W    = 10;
   localparam int CSR_W     = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_ONE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_ZERO   = 2'd2;

   localparam logic [8:0] PIXEL_COUNT_RESET = 9'd0;
   localparam logic [7:0] DUTY_ONE_RESET    = 8'd58;
   localparam logic [7:0] DUTY_ZERO_RESET   = 8'd29;

   localparam logic [1:0] OP_SET_PIXEL = 2'd0;
   localparam logic [1:0] OP_RENDER    = 2'd1;
   localparam logic [1:0] OP_REFILL    = 2'd2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_RANGE     = 3'd1;
   localparam logic [2:0] STATUS_CANCELLED = 3'd2;
   localparam logic [2:0] STATUS_FINISHED  = 3'd3;
   localparam logic [2:0] STATUS_IDLE      = 3'd4;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic       is_code;
      logic [7:0] duty;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_STAT,
      S_READ,
      S_LOAD,
      S_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take;
      logic       clr_step;
      logic       pix_write;
      logic       frame_clear;
      logic       frame_start;
      logic       slot_pixel;
      logic       slot_gap;
      logic       stat_set;
      logic [2:0] stat_code;
      logic       mem_read;
      logic       sreg_load;
      logic       code_emit;
      logic       code_last;
      logic       stat_emit;
      logic       pix_next;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       busy;
      logic       idx_ok;
      logic       slot_lt_cnt;
      logic       slot_lt_cnt2;
      logic       clr_done;
      logic       bit_end;
      logic       second_pending;
      logic       out_free;
   } flags_type;

endpackage

/* design/ws2_ctrl.sv */
// Controller state machine for the LED strip PWM frame encoder.
module ws2_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ws2_pkg::flags_type flags,
   output ws2_pkg::cmd_type   cmd
);
   import ws2_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (flags.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (flags.op)
               OP_SET_PIXEL: state_in = S_STAT;
               OP_RENDER: begin
                  state_in = flags.busy ? S_STAT : S_READ;
               end
               OP_REFILL: begin
                  if (!flags.busy)              state_in = S_STAT;
                  else if (flags.slot_lt_cnt)   state_in = S_READ;
                  else if (flags.slot_lt_cnt2)  state_in = S_EMIT;
                  else                          state_in = S_STAT;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_STAT: begin
            if (flags.out_free) state_in = S_IDLE;
         end
         S_READ:  state_in = S_LOAD;
         S_LOAD:  state_in = S_EMIT;
         S_EMIT: begin
            if (flags.out_free && flags.bit_end) begin
               state_in = flags.second_pending ? S_READ : S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: cmd.clr_step = 1'b1;
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         S_DECODE: begin
            case (flags.op)
               OP_SET_PIXEL: begin
                  cmd.pix_write = flags.idx_ok;
                  cmd.stat_set  = 1'b1;
                  cmd.stat_code = flags.idx_ok ? STATUS_OK : STATUS_RANGE;
               end
               OP_RENDER: begin
                  if (flags.busy) begin
                     cmd.frame_clear = 1'b1;
                     cmd.stat_set    = 1'b1;
                     cmd.stat_code   = STATUS_CANCELLED;
                  end else begin
                     cmd.frame_start = 1'b1;
                  end
               end
               OP_REFILL: begin
                  if (!flags.busy) begin
                     cmd.stat_set  = 1'b1;
                     cmd.stat_code = STATUS_IDLE;
                  end else if (flags.slot_lt_cnt) begin
                     cmd.slot_pixel = 1'b1;
                  end else if (flags.slot_lt_cnt2) begin
                     cmd.slot_gap = 1'b1;
                  end else begin
                     cmd.frame_clear = 1'b1;
                     cmd.stat_set    = 1'b1;
                     cmd.stat_code   = STATUS_FINISHED;
                  end
               end
               default: ;
            endcase
         end
         S_STAT: cmd.stat_emit = flags.out_free;
         S_READ: cmd.mem_read  = 1'b1;
         S_LOAD: cmd.sreg_load = 1'b1;
         S_EMIT: begin
            cmd.code_emit = flags.out_free;
            cmd.code_last = flags.bit_end && !flags.second_pending;
            cmd.pix_next  = flags.out_free && flags.bit_end && flags.second_pending;
         end
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   // Leave the clearing pass only once the whole store has been swept.
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && state_in == S_IDLE) |-> flags.clr_done)
      else $error("clearing pass ended early");
   // Never accept a new item while a pixel's codes are still going out.
   a_no_take_mid_pixel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> !req_ready)
      else $error("item accepted while codes pending");
   // A second pixel fetch follows only a render's first pixel.
   a_second_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.pix_next |=> (state_ff == S_READ))
      else $error("second pixel fetch lost");
`endif

endmodule

/* design/ws2_datapath.sv */
// Datapath: config registers, pixel store, frame position, code shifter, output register.
module ws2_datapath #(
   parameter int MAX_PIXELS     = 256,
   parameter int BITS_PER_PIXEL = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ws2_pkg::req_type                 req_data,
   input  logic                             csr_valid,
   input  logic [ws2_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ws2_pkg::CSR_W-1:0]        csr_wdata,
   input  ws2_pkg::cmd_type                 cmd,
   output ws2_pkg::flags_type               flags,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ws2_pkg::rsp_type                 rsp_data
);
   import ws2_pkg::*;

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;
   localparam int BW = (BITS_PER_PIXEL > 1) ? $clog2(BITS_PER_PIXEL) : 1;

   logic [8:0]         pixel_count_ff;
   logic [7:0]         duty_one_ff;
   logic [7:0]         duty_zero_ff;
   req_type            item_ff;
   logic [PIXEL_W-1:0] mem [MAX_PIXELS];
   logic [PIXEL_W-1:0] rd_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic               busy_ff;
   logic [SLOT_W-1:0]  next_slot_ff;
   logic [CW-1:0]      pix_ff;
   logic               px_ok_ff;
   logic               second_ff;
   logic               gap_ff;
   logic [PIXEL_W-1:0] sreg_ff;
   logic [BW-1:0]      bitcnt_ff;
   logic [2:0]         stat_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [CW-1:0]      cnt;
   logic [CW-1:0]      pc_ext;
   logic [CW-1:0]      idx_ext;
   logic [CW-1:0]      slot_ext;
   logic               out_free;
   logic [7:0]         code_duty;

   // Counts above the store depth act as the full store.
   assign pc_ext   = CW'(pixel_count_ff);
   assign cnt      = (pc_ext > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : pc_ext;
   assign idx_ext  = CW'(item_ff.pixel_index);
   assign slot_ext = CW'(next_slot_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      flags                = '0;
      flags.op             = item_ff.operation;
      flags.busy           = busy_ff;
      flags.idx_ok         = idx_ext < cnt;
      flags.slot_lt_cnt    = slot_ext < cnt;
      flags.slot_lt_cnt2   = slot_ext < (cnt + CW'(2));
      flags.clr_done       = clr_addr_ff == AW'(MAX_PIXELS - 1);
      flags.bit_end        = bitcnt_ff == BW'(BITS_PER_PIXEL - 1);
      flags.second_pending = second_ff;
      flags.out_free       = out_free;
   end

   // Config registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= PIXEL_COUNT_RESET;
         duty_one_ff    <= DUTY_ONE_RESET;
         duty_zero_ff   <= DUTY_ZERO_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PIXEL_COUNT: pixel_count_ff <= csr_wdata[8:0];
            CSR_DUTY_ONE:    duty_one_ff    <= csr_wdata[7:0];
            CSR_DUTY_ZERO:   duty_zero_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Item register.
   always_ff @(posedge clock) begin
      if (cmd.take) item_ff <= req_data;
   end

   // Pixel store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.pix_write) begin
         mem[idx_ext[AW-1:0]] <= {item_ff.green, item_ff.red, item_ff.blue};
      end
      if (cmd.mem_read) rd_ff <= mem[pix_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_step && !flags.clr_done) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // Frame position.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         next_slot_ff <= '0;
      end else if (cmd.frame_clear) begin
         busy_ff      <= 1'b0;
         next_slot_ff <= '0;
      end else if (cmd.frame_start) begin
         busy_ff      <= 1'b1;
         next_slot_ff <= SLOT_W'(2);
      end else if (cmd.slot_pixel || cmd.slot_gap) begin
         next_slot_ff <= next_slot_ff + 1'b1;
      end
   end

   // Pixel select, bit shifter and status hold.
   always_ff @(posedge clock) begin
      if (cmd.frame_start) begin
         pix_ff    <= '0;
         second_ff <= 1'b1;
         gap_ff    <= 1'b0;
      end else if (cmd.slot_pixel) begin
         pix_ff    <= slot_ext;
         second_ff <= 1'b0;
         gap_ff    <= 1'b0;
      end else if (cmd.slot_gap) begin
         second_ff <= 1'b0;
         gap_ff    <= 1'b1;
      end else if (cmd.pix_next) begin
         pix_ff    <= CW'(1);
         second_ff <= 1'b0;
      end
      if (cmd.mem_read) px_ok_ff <= pix_ff < cnt;
      if (cmd.sreg_load || cmd.slot_gap) begin
         // Pixels past the strip go out as color zero.
         sreg_ff   <= (cmd.sreg_load && px_ok_ff) ? rd_ff : '0;
         bitcnt_ff <= '0;
      end else if (cmd.code_emit) begin
         sreg_ff   <= {sreg_ff[PIXEL_W-2:0], 1'b0};
         bitcnt_ff <= bitcnt_ff + 1'b1;
      end
      if (cmd.stat_set) stat_ff <= cmd.stat_code;
   end

   assign code_duty = gap_ff ? 8'd0 : (sreg_ff[PIXEL_W-1] ? duty_one_ff : duty_zero_ff);

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.code_emit || cmd.stat_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.code_emit) begin
         rsp_data_ff <= '{is_code: 1'b1, duty: code_duty, status: STATUS_OK,
                          last: cmd.code_last};
      end else if (cmd.stat_emit) begin
         rsp_data_ff <= '{is_code: 1'b0, duty: 8'd0, status: stat_ff, last: 1'b1};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // Never overwrite a beat that has not been taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.code_emit || cmd.stat_emit) |-> out_free)
      else $error("result beat overwritten");
   // A code and a status never go out in the same cycle.
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      !(cmd.code_emit && cmd.stat_emit))
      else $error("two beats in one cycle");
   // A frame starts only when none is in progress.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.frame_start |-> !busy_ff)
      else $error("frame started while busy");
   // Reset gap slots carry zero duty.
   a_gap_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.code_emit && gap_ff) |=> (rsp_valid_ff && rsp_data_ff.duty == 8'd0))
      else $error("nonzero duty in reset gap");
`endif

endmodule

/* design/ws2812_pwm_frame_encoder_core.sv */
// Top level of the LED strip PWM frame encoder: controller plus datapath.
// A status item (set pixel, cancel, idle, finished) passes decode and a status state, then its beat is registered.
// Render shifts out two pixels, a pixel refill one pixel, a gap refill one slot of zero duty,
//   at one code per cycle while the output register is free, from the single shift register.
// Each pixel passes a pixel store read and a load state before its codes start.
// Reset is synchronous, active high; afterwards a clearing pass zeroes every entry of the
//   pixel store, one entry a cycle, while no item is taken (csr writes still are).
module ws2812_pwm_frame_encoder_core #(
   parameter int MAX_PIXELS     = 256,
   parameter int BITS_PER_PIXEL = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ws2_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ws2_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ws2_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ws2_pkg::CSR_W-1:0]     csr_wdata
);
   import ws2_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   // Register writes land directly in the config registers, so always take the beat.
   assign csr_ready = 1'b1;

   // Sequence each item: decode, then send a status beat or fetch a pixel (none for a gap) and shift out its codes.
   ws2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Hold the store, the frame position and the output register; the output
   // register lets a new item in while the last beat still waits.
   ws2_datapath #(
      .MAX_PIXELS     (MAX_PIXELS),
      .BITS_PER_PIXEL (BITS_PER_PIXEL)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
